FILE: design/gha_pkg.sv
`default_nettype none

package gha_pkg;

   // Table geometry
   localparam int SLOTS    = 256;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int GEN_BITS = 16;

   // Request command codes
   localparam logic [2:0] CMD_CREATE  = 3'd0;
   localparam logic [2:0] CMD_DESTROY = 3'd1;
   localparam logic [2:0] CMD_CHECK   = 3'd2;
   localparam logic [2:0] CMD_FLUSH   = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;

   // Response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic                occupied;
      logic                pending;
      logic [GEN_BITS-1:0] gen;
   } slot_entry_type;

   // One access to the slot table: optional read, optional write, or a clear
   typedef struct packed {
      logic             clear;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_entry_type   wr_data;
   } slot_cmd_type;

endpackage

`default_nettype wire

FILE: design/gha_slot_store.sv
`default_nettype none

module gha_slot_store (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire gha_pkg::slot_cmd_type   slot_cmd,
   output gha_pkg::slot_entry_type      rd_entry
);
   import gha_pkg::*;

   slot_entry_type   slot_mem_ff [SLOTS];
   logic [SLOTS-1:0] slot_vld_ff;
   slot_entry_type   rd_data_ff;
   logic             rd_vld_ff;

   // Write port and registered read port of the table
   always_ff @(posedge clock) begin
      if (slot_cmd.wr_en) begin
         slot_mem_ff[slot_cmd.wr_addr] <= slot_cmd.wr_data;
      end
      if (slot_cmd.rd_en) begin
         rd_data_ff <= slot_mem_ff[slot_cmd.rd_addr];
      end
   end

   // Per-entry written flags; an entry never written reads as all zero
   always_ff @(posedge clock) begin
      if (reset || slot_cmd.clear) begin
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (slot_cmd.wr_en) begin
            slot_vld_ff[slot_cmd.wr_addr] <= 1'b1;
         end
         if (slot_cmd.rd_en) begin
            rd_vld_ff <= slot_vld_ff[slot_cmd.rd_addr];
         end
      end
   end

   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: design/generational_handle_allocator_top.sv
`default_nettype none

// Generational handle allocator for 256 slots. A handle is a slot index plus
// a 16-bit generation; create pops the free stack (highest index first after
// reset or clear), destroy bumps the generation and queues the slot, flush
// returns queued slots to the free stack in queue order, check reports
// whether a handle names a live, non-pending slot. One transaction is worked
// at a time through a single read-modify-write port on the slot table; a
// flush makes one queue read and one slot-table read-modify-write per queued
// slot. A new request is taken in the idle state, which follows the
// registering of a result; a result waiting on rsp_ready stalls only the
// final step of the following transaction.
module generational_handle_allocator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_command,
   input  wire logic [15:0] req_handle_index,
   input  wire logic [15:0] req_handle_generation,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_slot_index,
   output logic [15:0]      rsp_slot_generation,
   output logic             rsp_handle_valid,
   output logic [8:0]       rsp_freed_count
);
   import gha_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_STACK,
      ST_SLOT,
      ST_FLUSH_QUEUE,
      ST_FLUSH_SLOT,
      ST_FLUSH_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [2:0]          cmd_ff, cmd_in;
   logic [15:0]         idx_ff, idx_in;
   logic [15:0]         hgen_ff, hgen_in;
   logic [IDX_W-1:0]    sel_ff, sel_in;
   logic [CNT_W-1:0]    fc_ff, fc_in;
   logic [CNT_W-1:0]    dc_ff, dc_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    freed_ff, freed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_index_ff, rsp_index_in;
   logic [15:0]         rsp_gen_ff, rsp_gen_in;
   logic                rsp_hvalid_ff, rsp_hvalid_in;
   logic [8:0]          rsp_freed_ff, rsp_freed_in;

   // Free stack memory with per-entry written flags
   logic [IDX_W-1:0]    stk_mem_ff [SLOTS];
   logic [SLOTS-1:0]    stk_vld_ff;
   logic [IDX_W-1:0]    stk_rd_ff;
   logic                stk_rd_vld_ff;
   logic [IDX_W-1:0]    stk_rd_addr_ff;
   logic                stk_rd_en;
   logic [IDX_W-1:0]    stk_rd_addr;
   logic                stk_wr_en;
   logic [IDX_W-1:0]    stk_wr_addr;
   logic [IDX_W-1:0]    stk_wr_data;
   logic                stk_clear;
   logic [IDX_W-1:0]    stk_entry;

   // Destroy queue memory, no reset
   logic [IDX_W-1:0]    q_mem_ff [SLOTS];
   logic [IDX_W-1:0]    q_rd_ff;
   logic                q_rd_en;
   logic [IDX_W-1:0]    q_rd_addr;
   logic                q_wr_en;
   logic [IDX_W-1:0]    q_wr_addr;
   logic [IDX_W-1:0]    q_wr_data;

   slot_cmd_type        slot_cmd;
   slot_entry_type      slot_entry;

   logic                out_free;
   logic                handle_ok;
   logic [CNT_W-1:0]    k_next;

   gha_slot_store u_slot_store (
      .clock    (clock),
      .reset    (reset),
      .slot_cmd (slot_cmd),
      .rd_entry (slot_entry)
   );

   // Free stack storage
   always_ff @(posedge clock) begin
      if (stk_wr_en) begin
         stk_mem_ff[stk_wr_addr] <= stk_wr_data;
      end
      if (stk_rd_en) begin
         stk_rd_ff      <= stk_mem_ff[stk_rd_addr];
         stk_rd_addr_ff <= stk_rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || stk_clear) begin
         stk_vld_ff    <= '0;
         stk_rd_vld_ff <= 1'b0;
      end else begin
         if (stk_wr_en) begin
            stk_vld_ff[stk_wr_addr] <= 1'b1;
         end
         if (stk_rd_en) begin
            stk_rd_vld_ff <= stk_vld_ff[stk_rd_addr];
         end
      end
   end

   // An unwritten stack entry holds its own position
   assign stk_entry = stk_rd_vld_ff ? stk_rd_ff : stk_rd_addr_ff;

   // Destroy queue storage
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         q_mem_ff[q_wr_addr] <= q_wr_data;
      end
      if (q_rd_en) begin
         q_rd_ff <= q_mem_ff[q_rd_addr];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign handle_ok = (32'(idx_ff) < SLOTS) && slot_entry.occupied && !slot_entry.pending
                      && (slot_entry.gen == hgen_ff);
   assign k_next    = k_ff + CNT_W'(1);

   // Sequencer: next state, memory controls and result
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      hgen_in       = hgen_ff;
      sel_in        = sel_ff;
      fc_in         = fc_ff;
      dc_in         = dc_ff;
      k_in          = k_ff;
      freed_in      = freed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_hvalid_in = rsp_hvalid_ff;
      rsp_freed_in  = rsp_freed_ff;

      stk_rd_en     = 1'b0;
      stk_rd_addr   = IDX_W'(fc_ff - CNT_W'(1));
      stk_wr_en     = 1'b0;
      stk_wr_addr   = fc_ff[IDX_W-1:0];
      stk_wr_data   = sel_ff;
      stk_clear     = 1'b0;
      q_rd_en       = 1'b0;
      q_rd_addr     = k_next[IDX_W-1:0];
      q_wr_en       = 1'b0;
      q_wr_addr     = dc_ff[IDX_W-1:0];
      q_wr_data     = idx_ff[IDX_W-1:0];
      slot_cmd      = '0;
      slot_cmd.rd_addr = sel_ff;
      slot_cmd.wr_addr = sel_ff;

      case (state_ff)
         ST_IDLE: begin
            // Capture the transaction
            if (req_valid) begin
               cmd_in   = req_command;
               idx_in   = req_handle_index;
               hgen_in  = req_handle_generation;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_CREATE: begin
                  if (fc_ff != '0) begin
                     stk_rd_en = 1'b1;
                     fc_in     = fc_ff - CNT_W'(1);
                     state_in  = ST_STACK;
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_NO_FREE;
                     rsp_index_in  = '0;
                     rsp_gen_in    = '0;
                     rsp_hvalid_in = 1'b0;
                     rsp_freed_in  = '0;
                     state_in      = ST_IDLE;
                  end
               end
               CMD_DESTROY, CMD_CHECK: begin
                  slot_cmd.rd_en   = 1'b1;
                  slot_cmd.rd_addr = idx_ff[IDX_W-1:0];
                  sel_in           = idx_ff[IDX_W-1:0];
                  state_in         = ST_SLOT;
               end
               CMD_FLUSH: begin
                  if (dc_ff != '0) begin
                     q_rd_en   = 1'b1;
                     q_rd_addr = '0;
                     k_in      = '0;
                     freed_in  = '0;
                     state_in  = ST_FLUSH_QUEUE;
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_index_in  = '0;
                     rsp_gen_in    = '0;
                     rsp_hvalid_in = 1'b0;
                     rsp_freed_in  = '0;
                     state_in      = ST_IDLE;
                  end
               end
               CMD_CLEAR: begin
                  if (out_free) begin
                     slot_cmd.clear = 1'b1;
                     stk_clear      = 1'b1;
                     fc_in          = CNT_W'(SLOTS);
                     dc_in          = '0;
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STATUS_OK;
                     rsp_index_in   = '0;
                     rsp_gen_in     = '0;
                     rsp_hvalid_in  = 1'b0;
                     rsp_freed_in   = '0;
                     state_in       = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_index_in  = '0;
                     rsp_gen_in    = '0;
                     rsp_hvalid_in = 1'b0;
                     rsp_freed_in  = '0;
                     state_in      = ST_IDLE;
                  end
               end
            endcase
         end

         ST_STACK: begin
            // Popped index arrives; fetch its slot entry
            slot_cmd.rd_en   = 1'b1;
            slot_cmd.rd_addr = stk_entry;
            sel_in           = stk_entry;
            state_in         = ST_SLOT;
         end

         ST_SLOT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = '0;
               rsp_gen_in    = '0;
               rsp_hvalid_in = 1'b0;
               rsp_freed_in  = '0;
               state_in      = ST_IDLE;
               case (cmd_ff)
                  CMD_CREATE: begin
                     slot_cmd.wr_en            = 1'b1;
                     slot_cmd.wr_data.occupied = 1'b1;
                     slot_cmd.wr_data.pending  = 1'b0;
                     slot_cmd.wr_data.gen      = slot_entry.gen;
                     rsp_index_in              = 8'(sel_ff);
                     rsp_gen_in                = 16'(slot_entry.gen);
                  end
                  CMD_DESTROY: begin
                     if (handle_ok && !dc_ff[IDX_W]) begin
                        slot_cmd.wr_en            = 1'b1;
                        slot_cmd.wr_data.occupied = 1'b1;
                        slot_cmd.wr_data.pending  = 1'b1;
                        slot_cmd.wr_data.gen      = slot_entry.gen + GEN_BITS'(1);
                        q_wr_en                   = 1'b1;
                        dc_in                     = dc_ff + CNT_W'(1);
                        rsp_hvalid_in             = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_INVALID;
                     end
                  end
                  default: begin
                     rsp_hvalid_in = handle_ok;
                  end
               endcase
            end
         end

         ST_FLUSH_QUEUE: begin
            // Queued index arrives; fetch its slot entry
            slot_cmd.rd_en   = 1'b1;
            slot_cmd.rd_addr = q_rd_ff;
            sel_in           = q_rd_ff;
            state_in         = ST_FLUSH_SLOT;
         end

         ST_FLUSH_SLOT: begin
            // Free the slot, push it back and advance along the queue
            slot_cmd.wr_en            = 1'b1;
            slot_cmd.wr_data.occupied = 1'b0;
            slot_cmd.wr_data.pending  = 1'b0;
            slot_cmd.wr_data.gen      = slot_entry.gen;
            if (!fc_ff[IDX_W]) begin
               stk_wr_en = 1'b1;
               fc_in     = fc_ff + CNT_W'(1);
               freed_in  = freed_ff + CNT_W'(1);
            end
            k_in = k_next;
            if (k_next == dc_ff) begin
               state_in = ST_FLUSH_DONE;
            end else begin
               q_rd_en  = 1'b1;
               state_in = ST_FLUSH_QUEUE;
            end
         end

         ST_FLUSH_DONE: begin
            if (out_free) begin
               dc_in         = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = '0;
               rsp_gen_in    = '0;
               rsp_hvalid_in = 1'b0;
               rsp_freed_in  = 9'(freed_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fc_ff        <= CNT_W'(SLOTS);
         dc_ff        <= '0;
         k_ff         <= '0;
         freed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         dc_ff        <= dc_in;
         k_ff         <= k_in;
         freed_ff     <= freed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      hgen_ff       <= hgen_in;
      sel_ff        <= sel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_hvalid_ff <= rsp_hvalid_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_index_ff;
   assign rsp_slot_generation = rsp_gen_ff;
   assign rsp_handle_valid    = rsp_hvalid_ff;
   assign rsp_freed_count     = rsp_freed_ff;

endmodule

`default_nettype wire

FILE: verif/generational_handle_allocator_top_tb.sv
`timescale 1ns / 1ps

module generational_handle_allocator_top_tb;
   import gha_pkg::*;

   localparam int     CLOCK_HALF_NS   = 4;
   localparam int     RANDOM_ITEMS    = 700;
   localparam int     ERROR_PRINT_MAX = 10;
   localparam int     SETTLE_CYCLES   = 20;
   localparam longint TIMEOUT_NS      = 8_000_000;

   // Command codes the block leaves unused
   localparam logic [2:0] CMD_SPARE_FIRST = CMD_CLEAR + 3'd1;
   localparam logic [2:0] CMD_SPARE_LAST  = '1;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  slot_index;
      logic [15:0] slot_generation;
      logic        handle_valid;
      logic [8:0]  freed_count;
   } alloc_result_type;

   typedef enum {PICK_LIVE, PICK_PENDING, PICK_FREE} slot_pick_type;

   logic        clock                 = 1'b0;
   logic        reset                 = 1'b1;
   logic        req_valid             = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command           = CMD_CHECK;
   logic [15:0] req_handle_index      = '0;
   logic [15:0] req_handle_generation = '0;
   logic        rsp_valid;
   logic        rsp_ready             = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_slot_index;
   logic [15:0] rsp_slot_generation;
   logic        rsp_handle_valid;
   logic [8:0]  rsp_freed_count;

   // Mirror of the allocator state
   logic [IDX_W-1:0]    model_free_stack    [SLOTS];
   logic [CNT_W-1:0]    model_free_count;
   logic [GEN_BITS-1:0] model_gen           [SLOTS];
   logic                model_occupied      [SLOTS];
   logic                model_pending       [SLOTS];
   logic [IDX_W-1:0]    model_destroy_queue [SLOTS];
   logic [CNT_W-1:0]    model_destroy_count;

   alloc_result_type expected_results[$];
   int               mismatch_count = 0;
   int               burst_left     = 0;
   logic [15:0]      stall_pattern  = '1;
   logic [6:0]       pattern_age    = '0;

   generational_handle_allocator_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_slot_generation   (rsp_slot_generation),
      .rsp_handle_valid      (rsp_handle_valid),
      .rsp_freed_count       (rsp_freed_count)
   );

   initial begin
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   // Restore the post-reset table: full free stack, every slot free at generation zero
   function automatic void model_clear();
      for (int i = 0; i < SLOTS; i++) begin
         model_free_stack[IDX_W'(i)]    = IDX_W'(i);
         model_gen[IDX_W'(i)]           = '0;
         model_occupied[IDX_W'(i)]      = 1'b0;
         model_pending[IDX_W'(i)]       = 1'b0;
         model_destroy_queue[IDX_W'(i)] = '0;
      end
      model_free_count    = CNT_W'(SLOTS);
      model_destroy_count = '0;
   endfunction

   function automatic bit handle_live(logic [15:0] idx, logic [15:0] gen);
      if (idx >= SLOTS) return 1'b0;
      return model_occupied[idx[IDX_W-1:0]] && !model_pending[idx[IDX_W-1:0]]
             && model_gen[idx[IDX_W-1:0]] == gen;
   endfunction

   // Apply one command to the mirror and return the result it should give
   function automatic alloc_result_type predict_result(logic [2:0] cmd, logic [15:0] idx,
                                                       logic [15:0] gen);
      alloc_result_type res;
      logic [IDX_W-1:0] s;
      res = '0;
      case (cmd)
         CMD_CREATE: begin
            if (model_free_count == 0) begin
               res.status = STATUS_NO_FREE;
            end else begin
               model_free_count    = model_free_count - CNT_W'(1);
               s                   = model_free_stack[model_free_count[IDX_W-1:0]];
               model_occupied[s]   = 1'b1;
               model_pending[s]    = 1'b0;
               res.slot_index      = s;
               res.slot_generation = model_gen[s];
            end
         end
         CMD_DESTROY: begin
            if (handle_live(idx, gen) && model_destroy_count < SLOTS) begin
               s                = idx[IDX_W-1:0];
               res.handle_valid = 1'b1;
               model_gen[s]     = model_gen[s] + GEN_BITS'(1);
               model_pending[s] = 1'b1;
               model_destroy_queue[model_destroy_count[IDX_W-1:0]] = s;
               model_destroy_count = model_destroy_count + CNT_W'(1);
            end else begin
               res.status = STATUS_INVALID;
            end
         end
         CMD_CHECK: begin
            res.handle_valid = handle_live(idx, gen);
         end
         CMD_FLUSH: begin
            // walk the queue in order, returning each slot to the free stack
            for (int k = 0; k < model_destroy_count; k++) begin
               s                 = model_destroy_queue[IDX_W'(k)];
               model_occupied[s] = 1'b0;
               model_pending[s]  = 1'b0;
               if (model_free_count < SLOTS) begin
                  model_free_stack[model_free_count[IDX_W-1:0]] = s;
                  model_free_count = model_free_count + CNT_W'(1);
                  res.freed_count  = res.freed_count + 9'd1;
               end
            end
            model_destroy_count = '0;
         end
         CMD_CLEAR: begin
            model_clear();
         end
         default: ;
      endcase
      return res;
   endfunction

   // Find a slot of the wanted kind, scanning from a random point; -1 if none
   function automatic int find_slot(slot_pick_type pick);
      int first, s;
      first = $urandom_range(0, SLOTS - 1);
      for (int n = 0; n < SLOTS; n++) begin
         s = (first + n) % SLOTS;
         case (pick)
            PICK_LIVE:    if (model_occupied[IDX_W'(s)] && !model_pending[IDX_W'(s)]) return s;
            PICK_PENDING: if (model_pending[IDX_W'(s)]) return s;
            default:      if (!model_occupied[IDX_W'(s)]) return s;
         endcase
      end
      return -1;
   endfunction

   // Offer one transaction, with a random gap at the start of each burst
   task automatic send_req(input logic [2:0] cmd, input logic [15:0] idx,
                           input logic [15:0] gen);
      alloc_result_type want;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      burst_left--;
      req_valid             <= 1'b1;
      req_command           <= cmd;
      req_handle_index      <= idx;
      req_handle_generation <= gen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want             = predict_result(cmd, idx, gen);
      expected_results = {expected_results, want};
   endtask

   // Hold off the sender until every outstanding result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Destroy or check with a handle that is mostly live, otherwise broken in some way
   task automatic send_handle_op(input logic [2:0] cmd);
      int          roll, s;
      logic [15:0] idx, gen;
      roll = $urandom_range(0, 99);
      idx  = 16'($urandom);
      gen  = 16'($urandom);
      if (roll < 80)      s = find_slot(PICK_LIVE);
      else if (roll < 87) s = find_slot(PICK_PENDING);
      else if (roll < 93) s = find_slot(PICK_FREE);
      else                s = -1;
      if (s >= 0) begin
         idx = 16'(s);
         gen = model_gen[IDX_W'(s)];
         // corrupt the generation, or present the pre-destroy one of a pending slot
         if (roll >= 70 && roll < 80) begin
            gen = gen + 16'($urandom_range(1, 65535));
         end else if (roll >= 80 && roll < 87 && $urandom_range(0, 1) == 1) begin
            gen = gen - 16'd1;
         end
      end else if (roll >= 93 && roll < 97) begin
         idx = 16'($urandom_range(SLOTS, 65535));
      end
      send_req(cmd, idx, gen);
   endtask

   task automatic test_directed();
      send_req(CMD_CHECK, '1, '1);
      send_req(CMD_DESTROY, '0, '0);
      send_req(CMD_FLUSH, '0, '0);
      send_req(CMD_CREATE, '0, '0);
      send_req(CMD_CREATE, '1, '1);
      send_req(CMD_CHECK, 16'(SLOTS - 1), 16'd0);
      send_req(CMD_CHECK, 16'(SLOTS - 1), 16'd1);
      send_req(CMD_DESTROY, 16'(SLOTS - 1), 16'd0);
      // stale handle, then the current generation of a pending slot
      send_req(CMD_DESTROY, 16'(SLOTS - 1), 16'd0);
      send_req(CMD_DESTROY, 16'(SLOTS - 1), 16'd1);
      send_req(CMD_CHECK, 16'(SLOTS - 1), 16'd1);
      send_req(CMD_DESTROY, 16'(SLOTS - 2), 16'd0);
      send_req(CMD_FLUSH, '1, '1);
      send_req(CMD_CREATE, '0, '0);
      send_req(CMD_CREATE, '0, '0);
      send_req(CMD_CHECK, 16'(SLOTS - 1), 16'd0);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
         send_req(3'(c), '1, '1);
      end
      send_req(CMD_CLEAR, '1, '1);
      send_req(CMD_CREATE, '0, '0);
      send_req(CMD_CHECK, 16'(SLOTS - 1), 16'd0);
      send_req(CMD_CHECK, 16'(SLOTS - 2), 16'd1);
   endtask

   // Fill the table, overrun it, destroy every slot in random order and flush them all
   task automatic test_full_table();
      int order[$];
      int j, tmp;
      send_req(CMD_CLEAR, 16'($urandom), 16'($urandom));
      while (model_free_count != 0) send_req(CMD_CREATE, 16'($urandom), 16'($urandom));
      send_req(CMD_CREATE, '1, '1);
      for (int s = 0; s < SLOTS; s++) begin
         if (model_occupied[IDX_W'(s)] && !model_pending[IDX_W'(s)]) order = {order, s};
      end
      for (int i = order.size() - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) send_req(CMD_DESTROY, 16'(order[i]), model_gen[IDX_W'(order[i])]);
      send_req(CMD_FLUSH, 16'($urandom), 16'($urandom));
      repeat (8) send_req(CMD_CREATE, 16'($urandom), 16'($urandom));
   endtask

   task automatic test_random(input int count);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)      send_req(CMD_CREATE, 16'($urandom), 16'($urandom));
         else if (roll < 65) send_handle_op(CMD_DESTROY);
         else if (roll < 90) send_handle_op(CMD_CHECK);
         else if (roll < 97) send_req(CMD_FLUSH, 16'($urandom), 16'($urandom));
         else if (roll < 98) send_req(CMD_CLEAR, 16'($urandom), 16'($urandom));
         else send_req(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                       16'($urandom), 16'($urandom));
      end
   endtask

   // Receiver readiness follows a rotating pattern, reloaded each time the 7-bit age counter wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         stall_pattern <= '1;
         pattern_age   <= '0;
      end else begin
         rsp_ready   <= stall_pattern[0];
         pattern_age <= pattern_age + 7'd1;
         if (pattern_age == '1) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
         end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      alloc_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_slot_index, rsp_slot_generation, rsp_handle_valid,
                rsp_freed_count};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ERROR_PRINT_MAX) begin
               $display("%0t: result with nothing outstanding: %p", $realtime, got);
            end
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= ERROR_PRINT_MAX) begin
                  $display("%0t: mismatch (expected/actual) status %0d/%0d index %0d/%0d",
                           $realtime, want.status, got.status, want.slot_index,
                           got.slot_index);
                  $display("   generation %0d/%0d valid %0d/%0d freed %0d/%0d",
                           want.slot_generation, got.slot_generation, want.handle_valid,
                           got.handle_valid, want.freed_count, got.freed_count);
               end
            end
         end
      end
   end

   initial begin
      model_clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_for_results();
      test_full_table();
      wait_for_results();
      test_random(RANDOM_ITEMS);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #TIMEOUT_NS;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
